### rtl/core/sshh_pkg.sv
// shared types and constants for the space-saving heavy-hitter table
`timescale 1ns / 1ps
package sshh_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned ReportMax = 32;
    localparam logic FuncUpdate = 1'b0;
    localparam logic FuncQuery  = 1'b1;
    typedef struct packed {
        logic [WordW-1:0] id;
        logic [WordW-1:0] count;
        logic [WordW-1:0] error;
    } t_entry;
endpackage

### rtl/core/sshh_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module sshh_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### rtl/core/space_saving_heavy_hitters.sv
// top level of the space-saving heavy-hitter table
// update: one scan over all entries, one memory read a cycle
// query: one selection scan per reported entry, waiting on output stalls between
//   passes; each pass finds the next entry in count/id order
// throughput: one item at a time; the next item is taken once the last result is registered
// reset: valid bits and occupancy cleared at once, no clearing pass, table empty
`timescale 1ns / 1ps
module space_saving_heavy_hitters #(
    parameter int CAPACITY = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // item_id, increment, threshold
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // out_id, out_count, out_error
    output logic         m_axis_tuser,  // valid_res
    output logic         m_axis_tlast   // last
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = 3 * sshh_pkg::WordW;
    localparam int FW = $clog2(sshh_pkg::ReportMax + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_QSCAN, S_QOUT} t_state;
    t_state r_state;

    logic [CAPACITY-1:0] r_valid;
    logic [CW-1:0] r_occ;
    logic [31:0] r_id, r_inc, r_thr;
    logic [AW:0] r_addr;     // read address issued, wider to hold the count
    logic [AW:0] r_rd_idx;   // index of data coming back
    logic r_rd_live;
    // update search
    logic r_hit;
    logic [AW-1:0] r_hit_idx;
    logic r_min_ok;
    logic [AW-1:0] r_min_idx;
    sshh_pkg::t_entry r_min, r_hit_e;
    logic r_free_ok;
    logic [AW-1:0] r_free_idx;
    // query selection: next entry strictly after the held one
    logic r_best_ok;
    sshh_pkg::t_entry r_best;
    logic r_pend_ok;          // an entry found by the previous pass waits to be sent
    sshh_pkg::t_entry r_pend;
    logic [FW-1:0] r_found;
    // output register
    logic r_ovalid;
    logic [RW-1:0] r_odata;
    logic r_ouser, r_olast;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    sshh_pkg::t_entry ram_wdata, rd;
    logic [AW-1:0] ram_raddr;

    sshh_ram #(.Width(RW), .Depth(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(rd)
    );

    assign ram_raddr = r_addr[AW-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;
    assign m_axis_tlast = r_olast;

    logic rd_v;
    logic [AW-1:0] ri;
    logic rank_lt_min, after_last, lt_best;
    logic [32:0] sum_hit, sum_min;
    logic out_free, out_load;
    always_comb begin
        ri = r_rd_idx[AW-1:0];
        rd_v = r_rd_live && r_valid[ri];
        rank_lt_min = (rd.count < r_min.count) ||
                      (rd.count == r_min.count && rd.id < r_min.id);
        after_last = !r_pend_ok || (rd.count > r_pend.count) ||
                     (rd.count == r_pend.count && rd.id > r_pend.id);
        lt_best = !r_best_ok || (rd.count < r_best.count) ||
                  (rd.count == r_best.count && rd.id < r_best.id);
        sum_hit = {1'b0, r_hit_e.count} + {1'b0, r_inc};
        sum_min = {1'b0, r_min.count} + {1'b0, r_inc};
        // output register takes a new item when empty or drained this cycle
        out_free = !r_ovalid || m_axis_tready;
        out_load = (r_state == S_QOUT) && out_free && (!r_best_ok || r_pend_ok);
        ram_we = 1'b0;
        ram_waddr = r_hit_idx;
        ram_wdata = r_hit_e;
        if (r_state == S_UPD) begin
            ram_we = 1'b1;
            if (r_hit) begin
                ram_waddr = r_hit_idx;
                ram_wdata.id = r_hit_e.id;
                ram_wdata.error = r_hit_e.error;
                ram_wdata.count = sum_hit[32] ? 32'hFFFF_FFFF : sum_hit[31:0];
            end else if (r_free_ok) begin
                ram_waddr = r_free_idx;
                ram_wdata.id = r_id;
                ram_wdata.count = r_inc;
                ram_wdata.error = '0;
            end else begin
                ram_waddr = r_min_idx;
                ram_wdata.id = r_id;
                ram_wdata.error = r_min.count;
                ram_wdata.count = sum_min[32] ? 32'hFFFF_FFFF : sum_min[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_occ <= '0;
            r_ovalid <= 1'b0;
            r_rd_live <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_id <= s_axis_tdata[31:0];
                        r_inc <= s_axis_tdata[63:32];
                        r_thr <= s_axis_tdata[95:64];
                        r_addr <= '0;
                        r_rd_live <= 1'b0;
                        r_hit <= 1'b0;
                        r_min_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_pend_ok <= 1'b0;
                        r_found <= '0;
                        r_state <= (s_axis_tuser == sshh_pkg::FuncQuery) ? S_QSCAN : S_SCAN;
                    end
                end
                S_SCAN, S_QSCAN: begin
                    // issue reads 0..CAPACITY-1, consume each in the cycle after
                    r_rd_live <= (r_addr < (AW+1)'(CAPACITY));
                    r_rd_idx <= r_addr;
                    if (r_addr < (AW+1)'(CAPACITY)) r_addr <= r_addr + (AW+1)'(1);
                    if (r_state == S_SCAN) begin
                        if (r_rd_live && !r_valid[ri] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free_idx <= ri;
                        end
                        if (rd_v && rd.id == r_id && !r_hit) begin
                            r_hit <= 1'b1;
                            r_hit_idx <= ri;
                            r_hit_e <= rd;
                        end
                        if (rd_v && (!r_min_ok || rank_lt_min)) begin
                            r_min_ok <= 1'b1;
                            r_min_idx <= ri;
                            r_min <= rd;
                        end
                    end else if (rd_v && rd.count >= r_thr && after_last && lt_best) begin
                        r_best_ok <= 1'b1;
                        r_best <= rd;
                    end
                    if (r_rd_live && r_rd_idx == (AW+1)'(CAPACITY - 1)) begin
                        r_state <= (r_state == S_SCAN) ? S_UPD : S_QOUT;
                    end
                end
                S_UPD: begin
                    if (!r_hit && r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_occ <= r_occ + CW'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_QOUT: begin
                    // the held entry goes out once the next pass shows whether it is last
                    if (out_free) begin
                        if (r_best_ok) begin
                            if (r_pend_ok) begin
                                r_odata <= {r_pend.error, r_pend.count, r_pend.id};
                                r_ouser <= 1'b1;
                                r_olast <= 1'b0;
                            end
                            r_pend <= r_best;
                            r_pend_ok <= 1'b1;
                            r_found <= r_found + FW'(1);
                            r_best_ok <= 1'b0;
                            r_addr <= '0;
                            // report full: skip the search and close with the held entry
                            r_state <= (r_found == FW'(sshh_pkg::ReportMax - 1)) ?
                                       S_QOUT : S_QSCAN;
                        end else begin
                            if (r_pend_ok) begin
                                r_odata <= {r_pend.error, r_pend.count, r_pend.id};
                                r_ouser <= 1'b1;
                            end else begin
                                // nothing qualifies: one empty item
                                r_odata <= '0;
                                r_ouser <= 1'b0;
                            end
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    property p_occ;
        @(posedge i_clk) disable iff (!i_rst_n) r_occ == CW'($countones(r_valid));
    endproperty
    a_occ: assert property (p_occ) else $error("occupancy mismatch");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> r_ovalid && $stable(r_odata))
        else $error("output dropped");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty report not last");
endmodule
